// ===== rtl/sdte_pkg.sv =====
// ----------------------------------------------------------------------------
// sdte_pkg
// Shared types, constants and helpers for the stereo dual-tap echo.
// ----------------------------------------------------------------------------
package sdte_pkg;

  localparam int unsigned LEN_W      = 17;  // tap length register
  localparam int unsigned GAIN_W     = 16;  // one channel of an input coefficient pair
  localparam int unsigned COEF_IN_W  = 16;  // feedback, cross mix, damping registers
  localparam int unsigned Q_W        = 17;  // saturated q1.15 coefficient, 0 .. 1.0
  localparam int unsigned COEF_W     = 18;  // signed coefficient operand of the mac
  localparam int unsigned FRAC_BITS  = 15;
  localparam int unsigned HALF_Q15   = 16384;
  localparam logic [Q_W-1:0] ONE_Q15 = Q_W'(32768);

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_TAP1_LEN   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAP2_LEN   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAP1_COEFS = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAP2_COEFS = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAP1_FB    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TAP2_FB    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CROSS_MIX  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING    = 4'd7;

  localparam logic [LEN_W-1:0]      RST_TAP_LEN   = 17'd1;
  localparam logic [CFG_DATA_W-1:0] RST_COEFS     = 32'd0;
  localparam logic [COEF_IN_W-1:0]  RST_FEEDBACK  = 16'd10240;
  localparam logic [COEF_IN_W-1:0]  RST_CROSS_MIX = 16'd25801;
  localparam logic [COEF_IN_W-1:0]  RST_DAMPING   = 16'd17285;

  typedef struct packed {
    logic en;     // take a product this cycle
    logic first;  // first product of a pair, restart from the rounding offset
  } mac_ctrl_t;

  // coefficients above one are held at one
  function automatic logic [Q_W-1:0] coef_sat(input logic [COEF_IN_W-1:0] c);
    logic [Q_W-1:0] r;
    r = (c > COEF_IN_W'(32768)) ? ONE_Q15 : {1'b0, c};
    return r;
  endfunction

  function automatic logic signed [COEF_W-1:0] to_op(input logic [Q_W-1:0] c);
    logic signed [COEF_W-1:0] r;
    r = $signed({1'b0, c});
    return r;
  endfunction

endpackage

// ===== rtl/stereo_dual_tap_echo.sv =====
// ----------------------------------------------------------------------------
// stereo_dual_tap_echo
// Two-tap stereo echo with crossfeed, feedback and one-pole damping.
// ----------------------------------------------------------------------------
//  channel  | handshake                     | payload
//  ---------+-------------------------------+--------------------------------
//  s_axis   | s_axis_tvalid / s_axis_tready | tdata: left_in, right_in
//           |                               | tlast: end_of_block
//  m_axis   | m_axis_tvalid / m_axis_tready | tdata: left_out, right_out
//           |                               | tlast: end_of_block_out
//  cfg      | cfg_valid_i / cfg_ready_o     | cfg_index_i, cfg_data_i
//
// Each stereo pair takes one fetch plus 12 products for each tap, all
// through the single multiply-accumulate unit, an output load and an idle
// state in which the next word is taken.
// Reset needs no clearing pass: a per-tap fill flag reads unwritten line entries
// as zero until the write index first wraps; a length write restarts both taps.
// The output register holds a result under back-pressure; the next pair is
// worked on meanwhile and waits in its final cycle until the register is free.
module stereo_dual_tap_echo #(
  parameter int unsigned MaxTapDepth = 65536,
  parameter int unsigned SampleBits  = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // left_in [SampleBits-1:0], right_in above it, zero fill
  input  logic [((2*SampleBits+7)/8)*8-1:0]    s_axis_tdata,
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // left_out [SampleBits-1:0], right_out above it, zero fill
  output logic [((2*SampleBits+7)/8)*8-1:0]    m_axis_tdata,
  output logic                                 m_axis_tlast,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [sdte_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [sdte_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned Sb      = SampleBits;
  localparam int unsigned TdataW  = ((2*SampleBits+7)/8)*8;
  localparam int unsigned IdxW    = $clog2(MaxTapDepth);
  localparam int unsigned LenEffW = (IdxW + 1 > sdte_pkg::LEN_W) ? IdxW + 1
                                                                 : sdte_pkg::LEN_W;
  localparam int unsigned OpAW    = Sb + 2;
  localparam int unsigned RndW    = OpAW + sdte_pkg::COEF_W - sdte_pkg::FRAC_BITS + 1;
  localparam int unsigned SumW    = Sb + 3;
  localparam int unsigned OutW    = Sb + 4;

  localparam logic signed [RndW-1:0] RndMax = {{(RndW-Sb+1){1'b0}}, {(Sb-1){1'b1}}};
  localparam logic signed [RndW-1:0] RndMin = ~RndMax;
  localparam logic signed [OutW-1:0] OutMax = {{(OutW-Sb+1){1'b0}}, {(Sb-1){1'b1}}};
  localparam logic signed [OutW-1:0] OutMin = ~OutMax;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_MAC   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam logic [3:0] OP_ML_A = 4'd0;
  localparam logic [3:0] OP_ML_B = 4'd1;
  localparam logic [3:0] OP_MR_A = 4'd2;
  localparam logic [3:0] OP_MR_B = 4'd3;
  localparam logic [3:0] OP_VL_A = 4'd4;
  localparam logic [3:0] OP_VL_B = 4'd5;
  localparam logic [3:0] OP_VR_A = 4'd6;
  localparam logic [3:0] OP_VR_B = 4'd7;
  localparam logic [3:0] OP_WL_A = 4'd8;
  localparam logic [3:0] OP_WL_B = 4'd9;
  localparam logic [3:0] OP_WR_A = 4'd10;
  localparam logic [3:0] OP_WR_B = 4'd11;

  // configuration
  logic [sdte_pkg::LEN_W-1:0]      tap_len_q   [2];
  logic [sdte_pkg::CFG_DATA_W-1:0] in_coefs_q  [2];
  logic [sdte_pkg::COEF_IN_W-1:0]  fb_q        [2];
  logic [sdte_pkg::COEF_IN_W-1:0]  cross_q;
  logic [sdte_pkg::COEF_IN_W-1:0]  damp_q;

  // tap state
  logic [IdxW-1:0]                 idx_q       [2];
  logic [1:0]                      fill_q;
  logic signed [Sb-1:0]            mem_l_q     [2];
  logic signed [Sb-1:0]            mem_r_q     [2];

  // sequencer and work registers
  logic [1:0]                      state_q, state_d;
  logic [3:0]                      op_q;
  logic                            tap_q;
  logic signed [Sb-1:0]            xl_q, xr_q;
  logic                            eob_q;
  logic signed [OpAW-1:0]          ml_q, mr_q, vl_q, vr_q;
  logic signed [Sb-1:0]            wl_q;
  logic signed [SumW-1:0]          sum_l_q, sum_r_q;

  // output register
  logic                            out_valid_q;
  logic signed [Sb-1:0]            out_l_q, out_r_q;
  logic                            out_last_q;

  logic [LenEffW-1:0]              len_eff     [2];
  logic [2*Sb-1:0]                 rdata       [2];
  logic [1:0]                      ram_we;
  logic signed [Sb-1:0]            dl, dr;
  logic signed [OpAW-1:0]          a_op;
  logic signed [sdte_pkg::COEF_W-1:0] b_op;
  logic signed [RndW-1:0]          rnd;
  logic signed [OpAW-1:0]          rnd_op;
  logic signed [Sb-1:0]            rnd_sat;
  logic [sdte_pkg::Q_W-1:0]        c_sat, d_sat;
  logic signed [sdte_pkg::COEF_W-1:0] fb_neg;
  logic [LenEffW-1:0]              idx_inc;
  logic                            in_acc, out_acc, cfg_acc, len_wr, out_load;
  logic                            mac_step, last_op;
  logic signed [OutW-1:0]          dbl_l, dbl_r;
  logic signed [Sb-1:0]            sat_l, sat_r;
  sdte_pkg::mac_ctrl_t             mac_ctrl;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_acc  = m_axis_tvalid && m_axis_tready;
  assign cfg_acc  = cfg_valid_i && cfg_ready_o;
  assign len_wr   = cfg_acc && (cfg_index_i == sdte_pkg::REG_TAP1_LEN ||
                                cfg_index_i == sdte_pkg::REG_TAP2_LEN);
  assign mac_step = (state_q == ST_MAC);
  assign last_op  = mac_step && (op_q == OP_WR_B);
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  // effective lengths: zero reads as one, above the line depth saturates
  always_comb begin
    for (int t = 0; t < 2; t++) begin
      if (tap_len_q[t] == '0) begin
        len_eff[t] = LenEffW'(1);
      end else if (LenEffW'(tap_len_q[t]) > LenEffW'(MaxTapDepth)) begin
        len_eff[t] = LenEffW'(MaxTapDepth);
      end else begin
        len_eff[t] = LenEffW'(tap_len_q[t]);
      end
    end
  end

  // delay lines, left in the low half of each word
  for (genvar g = 0; g < 2; g++) begin : gen_line
    assign ram_we[g] = last_op && (tap_q == 1'(g));
    sdte_ram #(
      .Width (2*Sb),
      .Depth (MaxTapDepth)
    ) u_line (
      .clk_i   (clk_i),
      .we_i    (ram_we[g]),
      .waddr_i (idx_q[g]),
      .wdata_i ({rnd_sat, wl_q}),
      .raddr_i (idx_q[g]),
      .rdata_o (rdata[g])
    );
  end

  assign dl = fill_q[tap_q] ? $signed(rdata[tap_q][Sb-1:0])    : '0;
  assign dr = fill_q[tap_q] ? $signed(rdata[tap_q][2*Sb-1:Sb]) : '0;

  assign c_sat  = sdte_pkg::coef_sat(cross_q);
  assign d_sat  = sdte_pkg::coef_sat(damp_q);
  assign fb_neg = -sdte_pkg::to_op(sdte_pkg::coef_sat(fb_q[tap_q]));

  // operand selection for the shared unit
  always_comb begin
    a_op = '0;
    b_op = '0;
    case (op_q)
      OP_ML_A: begin
        a_op = OpAW'(dl);
        b_op = sdte_pkg::to_op(sdte_pkg::ONE_Q15 - c_sat);
      end
      OP_ML_B: begin
        a_op = OpAW'(dr);
        b_op = sdte_pkg::to_op(c_sat);
      end
      OP_MR_A: begin
        a_op = OpAW'(dr);
        b_op = sdte_pkg::to_op(sdte_pkg::ONE_Q15 - c_sat);
      end
      OP_MR_B: begin
        a_op = OpAW'(dl);
        b_op = sdte_pkg::to_op(c_sat);
      end
      OP_VL_A: begin
        a_op = OpAW'(xl_q);
        b_op = sdte_pkg::to_op({1'b0, in_coefs_q[tap_q][sdte_pkg::GAIN_W-1:0]});
      end
      OP_VL_B: begin
        a_op = ml_q;
        b_op = fb_neg;
      end
      OP_VR_A: begin
        a_op = OpAW'(xr_q);
        b_op = sdte_pkg::to_op({1'b0,
                 in_coefs_q[tap_q][2*sdte_pkg::GAIN_W-1:sdte_pkg::GAIN_W]});
      end
      OP_VR_B: begin
        a_op = mr_q;
        b_op = fb_neg;
      end
      OP_WL_A: begin
        a_op = vl_q;
        b_op = sdte_pkg::to_op(d_sat);
      end
      OP_WL_B: begin
        a_op = OpAW'(mem_l_q[tap_q]);
        b_op = sdte_pkg::to_op(sdte_pkg::ONE_Q15 - d_sat);
      end
      OP_WR_A: begin
        a_op = vr_q;
        b_op = sdte_pkg::to_op(d_sat);
      end
      OP_WR_B: begin
        a_op = OpAW'(mem_r_q[tap_q]);
        b_op = sdte_pkg::to_op(sdte_pkg::ONE_Q15 - d_sat);
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  assign mac_ctrl.en    = mac_step;
  assign mac_ctrl.first = ~op_q[0];

  sdte_mac #(
    .OpW (OpAW)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (a_op),
    .b_i    (b_op),
    .rnd_o  (rnd)
  );

  assign rnd_op  = rnd[OpAW-1:0];
  assign rnd_sat = (rnd > RndMax) ? RndMax[Sb-1:0] :
                   (rnd < RndMin) ? RndMin[Sb-1:0] : rnd[Sb-1:0];

  assign idx_inc = LenEffW'(idx_q[tap_q]) + LenEffW'(1);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_FETCH;
      ST_FETCH: state_d = ST_MAC;
      ST_MAC:   if (op_q == OP_WR_B) state_d = tap_q ? ST_DONE : ST_FETCH;
      ST_DONE:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_ML_A;
      tap_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        tap_q <= 1'b0;
      end else if (last_op) begin
        tap_q <= 1'b1;
      end
      if (mac_step && !last_op) begin
        op_q <= op_q + 4'd1;
      end else begin
        op_q <= OP_ML_A;
      end
    end
  end

  // input word and intermediate values
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      xl_q    <= $signed(s_axis_tdata[Sb-1:0]);
      xr_q    <= $signed(s_axis_tdata[2*Sb-1:Sb]);
      eob_q   <= s_axis_tlast;
      sum_l_q <= '0;
      sum_r_q <= '0;
    end
    if (mac_step) begin
      case (op_q)
        OP_ML_B: ml_q <= rnd_op;
        OP_MR_B: mr_q <= rnd_op;
        OP_VL_B: begin
          vl_q    <= rnd_op;
          sum_l_q <= sum_l_q + SumW'(rnd_op);
        end
        OP_VR_B: begin
          vr_q    <= rnd_op;
          sum_r_q <= sum_r_q + SumW'(rnd_op);
        end
        OP_WL_B: wl_q <= rnd_sat;
        default: ;
      endcase
    end
  end

  // configuration registers and tap state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_len_q[0]  <= sdte_pkg::RST_TAP_LEN;
      tap_len_q[1]  <= sdte_pkg::RST_TAP_LEN;
      in_coefs_q[0] <= sdte_pkg::RST_COEFS;
      in_coefs_q[1] <= sdte_pkg::RST_COEFS;
      fb_q[0]       <= sdte_pkg::RST_FEEDBACK;
      fb_q[1]       <= sdte_pkg::RST_FEEDBACK;
      cross_q       <= sdte_pkg::RST_CROSS_MIX;
      damp_q        <= sdte_pkg::RST_DAMPING;
      idx_q[0]      <= '0;
      idx_q[1]      <= '0;
      fill_q        <= '0;
      mem_l_q[0]    <= '0;
      mem_l_q[1]    <= '0;
      mem_r_q[0]    <= '0;
      mem_r_q[1]    <= '0;
    end else begin
      if (cfg_acc) begin
        unique case (cfg_index_i)
          sdte_pkg::REG_TAP1_LEN:   tap_len_q[0]  <= cfg_data_i[sdte_pkg::LEN_W-1:0];
          sdte_pkg::REG_TAP2_LEN:   tap_len_q[1]  <= cfg_data_i[sdte_pkg::LEN_W-1:0];
          sdte_pkg::REG_TAP1_COEFS: in_coefs_q[0] <= cfg_data_i;
          sdte_pkg::REG_TAP2_COEFS: in_coefs_q[1] <= cfg_data_i;
          sdte_pkg::REG_TAP1_FB:    fb_q[0] <= cfg_data_i[sdte_pkg::COEF_IN_W-1:0];
          sdte_pkg::REG_TAP2_FB:    fb_q[1] <= cfg_data_i[sdte_pkg::COEF_IN_W-1:0];
          sdte_pkg::REG_CROSS_MIX:  cross_q <= cfg_data_i[sdte_pkg::COEF_IN_W-1:0];
          sdte_pkg::REG_DAMPING:    damp_q  <= cfg_data_i[sdte_pkg::COEF_IN_W-1:0];
          default: ;
        endcase
      end
      if (len_wr) begin
        // both taps restart from empty lines
        idx_q[0]   <= '0;
        idx_q[1]   <= '0;
        fill_q     <= '0;
        mem_l_q[0] <= '0;
        mem_l_q[1] <= '0;
        mem_r_q[0] <= '0;
        mem_r_q[1] <= '0;
      end else if (last_op) begin
        mem_l_q[tap_q] <= wl_q;
        mem_r_q[tap_q] <= rnd_sat;
        if (idx_inc >= len_eff[tap_q]) begin
          idx_q[tap_q]  <= '0;
          fill_q[tap_q] <= 1'b1;
        end else begin
          idx_q[tap_q] <= idx_inc[IdxW-1:0];
        end
      end
    end
  end

  // output sum, doubled and saturated
  assign dbl_l = {sum_l_q, 1'b0};
  assign dbl_r = {sum_r_q, 1'b0};
  assign sat_l = (dbl_l > OutMax) ? OutMax[Sb-1:0] :
                 (dbl_l < OutMin) ? OutMin[Sb-1:0] : dbl_l[Sb-1:0];
  assign sat_r = (dbl_r > OutMax) ? OutMax[Sb-1:0] :
                 (dbl_r < OutMin) ? OutMin[Sb-1:0] : dbl_r[Sb-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_l_q    <= sat_l;
      out_r_q    <= sat_r;
      out_last_q <= eob_q;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TdataW'({out_r_q, out_l_q});
  assign m_axis_tlast  = out_last_q;
  assign cfg_ready_o   = 1'b1;

  // second tap's last product always hands over to the output stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_op && tap_q) |=> (state_q == ST_DONE))
    else $error("sequencer did not reach output stage after second tap");

  // a length write restarts both taps from empty lines
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_wr |=> (fill_q == 2'b00 && idx_q[0] == '0 && idx_q[1] == '0))
    else $error("length write did not restart the taps");

  // write indices stay inside the effective lengths
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (LenEffW'(idx_q[0]) < len_eff[0]) && (LenEffW'(idx_q[1]) < len_eff[1]))
    else $error("tap index beyond its length");

  // a result is loaded only after both taps have been worked through
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (tap_q && $past(state_q) != ST_IDLE))
    else $error("output loaded before both taps finished");

endmodule

// ===== rtl/sdte_ram.sv =====
// ----------------------------------------------------------------------------
// sdte_ram
// Simple dual-port ram: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sdte_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sdte_mac.sv =====
// ----------------------------------------------------------------------------
// sdte_mac
// Shared multiply-accumulate unit: sums two q1.15 products with round half up.
// ----------------------------------------------------------------------------
module sdte_mac #(
  parameter int unsigned OpW = 26
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  sdte_pkg::mac_ctrl_t                   ctrl_i,
  input  logic signed [OpW-1:0]                 a_i,
  input  logic signed [sdte_pkg::COEF_W-1:0]    b_i,
  output logic signed [OpW+sdte_pkg::COEF_W-sdte_pkg::FRAC_BITS:0] rnd_o
);

  localparam int unsigned ProdW = OpW + sdte_pkg::COEF_W;
  localparam int unsigned AccW  = ProdW + 1;

  logic signed [ProdW-1:0] prod;
  logic signed [AccW-1:0]  base;
  logic signed [AccW-1:0]  acc_d;
  logic signed [AccW-1:0]  acc_q;

  assign prod  = ProdW'(a_i) * ProdW'(b_i);
  assign base  = ctrl_i.first ? $signed(AccW'(sdte_pkg::HALF_Q15)) : acc_q;
  assign acc_d = base + AccW'(prod);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.en) begin
      acc_q <= acc_d;
    end
  end

  // floor of (sum + half) / 2^15
  assign rnd_o = acc_d[AccW-1:sdte_pkg::FRAC_BITS];

endmodule

// ===== test/sdte_echo_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sdte_echo_checker
// Watches the sample, result and register channels of the stereo echo, keeps
// its own copy of the delay lines and coefficients, predicts every output
// pair and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
module sdte_echo_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_valid_i,
  input  logic                            s_ready_i,
  input  logic [47:0]                     s_data_i,   // left_in [23:0], right_in [47:24]
  input  logic                            s_last_i,
  input  logic                            m_valid_i,
  input  logic                            m_ready_i,
  input  logic [47:0]                     m_data_i,   // left_out [23:0], right_out [47:24]
  input  logic                            m_last_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [sdte_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sdte_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              mismatch_count_o,
  output int                              pending_o
);

  localparam int unsigned LEN_W      = sdte_pkg::LEN_W;
  localparam int unsigned COEF_IN_W  = sdte_pkg::COEF_IN_W;
  localparam int unsigned CFG_IDX_W  = sdte_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W = sdte_pkg::CFG_DATA_W;
  localparam int unsigned LINE_DEPTH = 65536;
  localparam longint      SMP_MAX    = 64'sd8388607;
  localparam longint      SMP_MIN    = -64'sd8388608;
  localparam longint      Q15_ONE    = 64'sd32768;

  typedef struct packed {
    logic [23:0] left;
    logic [23:0] right;
    logic        eob;
  } stereo_word_t;

  // delay lines and filter memories, index 0 is tap one
  logic signed [23:0] line_l [2][LINE_DEPTH];
  logic signed [23:0] line_r [2][LINE_DEPTH];
  int unsigned        tap_pos [2];
  longint             damp_l [2];
  longint             damp_r [2];

  logic [LEN_W-1:0]      len_reg  [2];
  logic [CFG_DATA_W-1:0] gain_reg [2];
  logic [COEF_IN_W-1:0]  fb_reg   [2];
  logic [COEF_IN_W-1:0]  xmix_reg;
  logic [COEF_IN_W-1:0]  damp_reg;

  stereo_word_t echo_queue [$];
  int           mismatches;

  function automatic longint round_q15(input longint x);
    return (x + 64'sd16384) >>> 15;
  endfunction

  function automatic longint clamp_sample(input longint v);
    if (v > SMP_MAX) return SMP_MAX;
    if (v < SMP_MIN) return SMP_MIN;
    return v;
  endfunction

  function automatic longint q15_limit(input logic [COEF_IN_W-1:0] c);
    return (c > 16'd32768) ? Q15_ONE : longint'(c);
  endfunction

  function automatic int unsigned tap_span(input logic [LEN_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > LINE_DEPTH) return LINE_DEPTH;
    return int'(raw);
  endfunction

  // a length write restarts both taps from silence
  function automatic void flush_lines();
    for (int t = 0; t < 2; t++) begin
      for (int i = 0; i < LINE_DEPTH; i++) begin
        line_l[t][i] = '0;
        line_r[t][i] = '0;
      end
      tap_pos[t] = 0;
      damp_l[t]  = 0;
      damp_r[t]  = 0;
    end
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      sdte_pkg::REG_TAP1_LEN: begin
        len_reg[0] = data[LEN_W-1:0];
        flush_lines();
      end
      sdte_pkg::REG_TAP2_LEN: begin
        len_reg[1] = data[LEN_W-1:0];
        flush_lines();
      end
      sdte_pkg::REG_TAP1_COEFS: gain_reg[0] = data;
      sdte_pkg::REG_TAP2_COEFS: gain_reg[1] = data;
      sdte_pkg::REG_TAP1_FB:    fb_reg[0]   = data[COEF_IN_W-1:0];
      sdte_pkg::REG_TAP2_FB:    fb_reg[1]   = data[COEF_IN_W-1:0];
      sdte_pkg::REG_CROSS_MIX:  xmix_reg    = data[COEF_IN_W-1:0];
      sdte_pkg::REG_DAMPING:    damp_reg    = data[COEF_IN_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void run_tap(input int t, input longint xl, input longint xr,
                                  output longint vl, output longint vr);
    longint      c, d, fb, dl, dr, ml, mr, gl, gr, wl, wr;
    int unsigned k;
    c  = q15_limit(xmix_reg);
    d  = q15_limit(damp_reg);
    fb = q15_limit(fb_reg[t]);
    k  = tap_pos[t];
    dl = line_l[t][k];
    dr = line_r[t][k];
    ml = round_q15(dl * (Q15_ONE - c) + dr * c);
    mr = round_q15(dr * (Q15_ONE - c) + dl * c);
    gl = longint'(gain_reg[t][15:0]);
    gr = longint'(gain_reg[t][31:16]);
    vl = round_q15(xl * gl - ml * fb);
    vr = round_q15(xr * gr - mr * fb);
    wl = clamp_sample(round_q15(vl * d + damp_l[t] * (Q15_ONE - d)));
    wr = clamp_sample(round_q15(vr * d + damp_r[t] * (Q15_ONE - d)));
    line_l[t][k] = wl[23:0];
    line_r[t][k] = wr[23:0];
    damp_l[t] = wl;
    damp_r[t] = wr;
    k++;
    if (k >= tap_span(len_reg[t])) k = 0;
    tap_pos[t] = k;
  endfunction

  function automatic stereo_word_t predict_echo(input logic [47:0] data, input logic eob);
    longint       xl, xr, l1, r1, l2, r2, ol, orr;
    stereo_word_t w;
    xl = longint'($signed(data[23:0]));
    xr = longint'($signed(data[47:24]));
    run_tap(0, xl, xr, l1, r1);
    run_tap(1, xl, xr, l2, r2);
    ol  = clamp_sample(2 * (l1 + l2));
    orr = clamp_sample(2 * (r1 + r2));
    w.left  = ol[23:0];
    w.right = orr[23:0];
    w.eob   = eob;
    return w;
  endfunction

  function automatic void check_field(input string what, input longint want,
                                      input longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : watch
    stereo_word_t want;
    if (!rst_ni) begin
      len_reg[0]  = sdte_pkg::RST_TAP_LEN;
      len_reg[1]  = sdte_pkg::RST_TAP_LEN;
      gain_reg[0] = sdte_pkg::RST_COEFS;
      gain_reg[1] = sdte_pkg::RST_COEFS;
      fb_reg[0]   = sdte_pkg::RST_FEEDBACK;
      fb_reg[1]   = sdte_pkg::RST_FEEDBACK;
      xmix_reg    = sdte_pkg::RST_CROSS_MIX;
      damp_reg    = sdte_pkg::RST_DAMPING;
      flush_lines();
      echo_queue.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) apply_register(cfg_index_i, cfg_data_i);
      if (s_valid_i && s_ready_i) echo_queue.push_back(predict_echo(s_data_i, s_last_i));
      if (m_valid_i && m_ready_i) begin
        if (echo_queue.size() == 0) begin
          mismatches++;
          $display("%0t: output word with nothing expected, actual left %0d right %0d last %0b",
                   $time, $signed(m_data_i[23:0]), $signed(m_data_i[47:24]), m_last_i);
        end else begin
          want = echo_queue.pop_front();
          check_field("left_out", longint'($signed(want.left)),
                      longint'($signed(m_data_i[23:0])));
          check_field("right_out", longint'($signed(want.right)),
                      longint'($signed(m_data_i[47:24])));
          check_field("end_of_block_out", longint'(want.eob), longint'(m_last_i));
        end
      end
    end
    mismatch_count_o <= mismatches;
    pending_o        <= echo_queue.size();
  end

endmodule

// ===== test/tb_stereo_dual_tap_echo.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stereo_dual_tap_echo
// Drives stereo sample words and register writes into the two-tap echo under
// random flow control, with a long output hold-off and a full drain, and
// reports the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module tb_stereo_dual_tap_echo;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned LEN_W       = sdte_pkg::LEN_W;
  localparam int unsigned COEF_IN_W   = sdte_pkg::COEF_IN_W;
  localparam int unsigned CFG_IDX_W   = sdte_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W  = sdte_pkg::CFG_DATA_W;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [47:0]           s_axis_tdata;   // left_in [23:0], right_in [47:24]
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [47:0]           m_axis_tdata;   // left_out [23:0], right_out [47:24]
  logic                  m_axis_tlast;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int          mismatch_count;
  int          pending_pairs;
  int unsigned cycle_count = 0;
  logic        receiver_hold;
  logic        steady_flow;

  stereo_dual_tap_echo u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  sdte_echo_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_valid_i        (s_axis_tvalid),
    .s_ready_i        (s_axis_tready),
    .s_data_i         (s_axis_tdata),
    .s_last_i         (s_axis_tlast),
    .m_valid_i        (m_axis_tvalid),
    .m_ready_i        (m_axis_tready),
    .m_data_i         (m_axis_tdata),
    .m_last_i         (m_axis_tlast),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_pairs)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (receiver_hold) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady_flow || ($urandom_range(99) >= 34);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [23:0] pick_sample();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 24'($urandom);
    if (r < 80) return 24'($urandom_range(8191)) - 24'd4096;
    case ($urandom_range(3))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return 24'h000000;
      default: return 24'hFFFFFF;
    endcase
  endfunction

  // mostly short lines so echoes come back, now and then the far ends
  function automatic logic [CFG_DATA_W-1:0] length_word();
    int unsigned      r;
    logic [LEN_W-1:0] len;
    r = $urandom_range(99);
    if (r < 70)      len = LEN_W'($urandom_range(40, 1));
    else if (r < 85) len = LEN_W'($urandom_range(700, 41));
    else if (r < 92) len = LEN_W'($urandom_range(65536, 65530));
    else if (r < 96) len = '0;
    else             len = LEN_W'($urandom_range(131071, 65537));
    if ($urandom_range(3) == 0) return {15'($urandom), len};
    return {15'd0, len};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] q15_word();
    int unsigned          r;
    logic [COEF_IN_W-1:0] c;
    r = $urandom_range(99);
    if (r < 50)      c = COEF_IN_W'($urandom_range(32768));
    else if (r < 62) c = 16'd32768;
    else if (r < 70) c = 16'd0;
    else if (r < 82) c = COEF_IN_W'($urandom_range(65535, 32769));
    else             c = COEF_IN_W'($urandom_range(32768, 16384));
    if ($urandom_range(3) == 0) return {16'($urandom), c};
    return {16'd0, c};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] gain_word();
    case ($urandom_range(4))
      0:       return 32'hFFFF_FFFF;
      1:       return 32'h8000_8000;
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_all(input logic [CFG_DATA_W-1:0] len1, input logic [CFG_DATA_W-1:0] len2,
                             input logic [CFG_DATA_W-1:0] g1, input logic [CFG_DATA_W-1:0] g2,
                             input logic [CFG_DATA_W-1:0] fb1, input logic [CFG_DATA_W-1:0] fb2,
                             input logic [CFG_DATA_W-1:0] xmix, input logic [CFG_DATA_W-1:0] damp);
    write_reg(sdte_pkg::REG_TAP1_LEN, len1);
    write_reg(sdte_pkg::REG_TAP2_LEN, len2);
    write_reg(sdte_pkg::REG_TAP1_COEFS, g1);
    write_reg(sdte_pkg::REG_TAP2_COEFS, g2);
    write_reg(sdte_pkg::REG_TAP1_FB, fb1);
    write_reg(sdte_pkg::REG_TAP2_FB, fb2);
    write_reg(sdte_pkg::REG_CROSS_MIX, xmix);
    write_reg(sdte_pkg::REG_DAMPING, damp);
  endtask

  task automatic send_pair(input logic [23:0] left, input logic [23:0] right, input logic eob);
    while (!steady_flow && $urandom_range(99) < 34) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {right, left};
    s_axis_tlast  <= eob;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // sender stops until every expected pair is back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_pairs != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(input int count, input bit hold_off, input bit pause_midway);
    for (int i = 0; i < count; i++) begin
      if (hold_off && i == 2) begin
        fork
          begin
            receiver_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk_i);
            receiver_hold <= 1'b0;
          end
        join_none
      end
      if (pause_midway && i == count / 2) wait_drained();
      send_pair(pick_sample(), pick_sample(), $urandom_range(7) == 0);
    end
    wait_drained();
  endtask

  logic [23:0] corner_l [12] = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF,
                                 24'h7FFFFF, 24'h800000, 24'h555555, 24'hAAAAAA,
                                 24'h000001, 24'h400000, 24'h7FFFFF, 24'h123456};
  logic [23:0] corner_r [12] = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'h000001,
                                 24'h800000, 24'h7FFFFF, 24'hAAAAAA, 24'h555555,
                                 24'hFFFFFF, 24'hC00000, 24'h7FFFFF, 24'hEDCBA9};

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    receiver_hold = 1'b0;
    steady_flow   = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: zero input gain, so silence out
    send_pair(24'h7FFFFF, 24'h800000, 1'b1);
    send_pair(24'h800000, 24'h7FFFFF, 1'b0);
    wait_drained();

    // full crossfeed, feedback at and above one, gains up to two, no damping
    program_all(32'd2, 32'd3, 32'h8000_FFFF, 32'hFFFF_8000,
                32'd32768, 32'd65535, 32'd65535, 32'd32768);
    for (int i = 0; i < 12; i++) send_pair(corner_l[i], corner_r[i], i[0]);
    for (int i = 0; i < 8; i++) send_pair(24'h000000, 24'h000000, i == 7);
    wait_drained();

    // zero length and oversize length, tap two gains at most, all else at zero
    program_all(32'd0, 32'h0001_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                32'd0, 32'd0, 32'd0, 32'd0);
    run_phase(60, 1'b0, 1'b0);

    // shortest and deepest lines, gains just under two, all else at one
    program_all(32'd1, 32'h0001_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'd32768, 32'd65535, 32'd32768, 32'd32768);
    run_phase(80, 1'b0, 1'b0);

    for (int j = 0; j < 10; j++) begin
      if (j == 0 || $urandom_range(1) == 1) begin
        write_reg(sdte_pkg::REG_TAP1_LEN, length_word());
        write_reg(sdte_pkg::REG_TAP2_LEN, length_word());
      end
      write_reg(sdte_pkg::REG_TAP1_COEFS, gain_word());
      write_reg(sdte_pkg::REG_TAP2_COEFS, gain_word());
      write_reg(sdte_pkg::REG_TAP1_FB, q15_word());
      write_reg(sdte_pkg::REG_TAP2_FB, q15_word());
      write_reg(sdte_pkg::REG_CROSS_MIX, q15_word());
      write_reg(sdte_pkg::REG_DAMPING, q15_word());
      // indexes past the last register must change nothing
      write_reg(CFG_IDX_W'($urandom_range(15, int'(sdte_pkg::REG_DAMPING) + 1)), $urandom);
      steady_flow <= (j == 2);
      run_phase(100, j == 4, j == 6);
    end
    steady_flow <= 1'b0;

    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0 && pending_pairs == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
